// ----- src/opt_pkg.sv -----
package opt_pkg;

    localparam int INDEX_WIDTH = 32;
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int TDATA_W     = 48;
    localparam int TUSER_W     = 2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic                   parse_error;
        logic                   done_ok;
        logic [VALUE_W-1:0]     index_value;
        logic                   name_end;
        logic [CHAR_W-1:0]      name_char;
    } result_data_t;

    typedef struct packed {
        logic index_valid;
        logic name_char_valid;
    } result_user_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_ctrl(input logic [CHAR_W-1:0] b);
        return (b == CH_DOT) || (b == CH_OPEN) || (b == CH_CLOSE) || (b == CH_BSL);
    endfunction

endpackage

// ----- src/object_path_tokenizer_core.sv -----
// Object path tokenizer: one path byte per item in, one result item out.
// Input channel: s_tdata carries the byte, s_tlast marks the final byte of
// the path. Output channel: m_tdata carries the name byte, name end, index
// value, success and error flags; m_tuser says whether a name byte or an
// index is present. Every input item yields exactly one result item.
// The result of an accepted byte is registered in the output register and
// presented in the cycle after it is accepted. Throughput is one item per
// cycle when not stalled, limited only by the single output register; a new
// byte is taken in the same cycle that the held result is taken.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the output register and puts
// the parser at the start of a path with a zero index. After an error,
// bytes give all-zero results until the last byte, which also restarts the
// parser; every last byte restarts it.
module object_path_tokenizer_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [opt_pkg::CHAR_W-1:0]  s_tdata,  // [7:0] char_code
    input  logic                   s_tlast,       // is_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] name_char, [8] name_end, [40:9] index_value, [41] done_ok,
    // [42] parse_error, [47:43] zero
    output logic [opt_pkg::TDATA_W-1:0] m_tdata,
    // [0] name_char_valid, [1] index_valid
    output logic [opt_pkg::TUSER_W-1:0] m_tuser
);
    import opt_pkg::*;

    typedef enum logic [3:0] {
        M_START,
        M_NAME_FIRST,
        M_NAME,
        M_ESC,
        M_IDX_PRE,
        M_IDX_NUM,
        M_IDX_POST,
        M_AFTER,
        M_ERROR
    } mode_t;

    localparam int PROD_W = INDEX_WIDTH + 4;

    mode_t                  mode_reg, mode_next;
    logic [INDEX_WIDTH-1:0] acc_reg, acc_next;
    logic                   m_valid_reg;
    result_data_t           data_reg, data_next;
    result_user_t           user_reg, user_next;

    logic                   accept;
    logic                   err;
    mode_t                  m;
    logic [CHAR_W-1:0]      b;
    logic [PROD_W-1:0]      digit_ext;
    logic [PROD_W-1:0]      prod;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - $bits(result_data_t)){1'b0}}, data_reg};
    assign m_tuser  = user_reg;

    assign b         = s_tdata;
    assign digit_ext = PROD_W'(b - CH_ZERO);
    assign prod      = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + digit_ext;

    always_comb begin
        data_next = '0;
        user_next = '0;
        err       = 1'b0;
        m         = mode_reg;
        acc_next  = acc_reg;
        mode_next = mode_reg;

        if (mode_reg == M_ERROR) begin
            mode_next = s_tlast ? M_START : M_ERROR;
            if (s_tlast) begin
                acc_next = '0;
            end
        end else begin
            if (b == CH_NUL) begin
                err = 1'b1;
            end else if (mode_reg == M_START && b == CH_OPEN) begin
                m = M_IDX_PRE;
            end else if (mode_reg == M_START || mode_reg == M_NAME_FIRST
                         || mode_reg == M_NAME) begin
                if (b == CH_DOT || b == CH_OPEN) begin
                    if (mode_reg == M_NAME) begin
                        data_next.name_end = 1'b1;
                        m = (b == CH_DOT) ? M_NAME_FIRST : M_IDX_PRE;
                    end else begin
                        err = 1'b1;
                    end
                end else if (b == CH_CLOSE) begin
                    err = 1'b1;
                end else if (b == CH_BSL) begin
                    m = M_ESC;
                end else begin
                    user_next.name_char_valid = 1'b1;
                    data_next.name_char       = b;
                    m = M_NAME;
                end
            end else if (mode_reg == M_ESC) begin
                if (is_ctrl(b)) begin
                    user_next.name_char_valid = 1'b1;
                    data_next.name_char       = b;
                    m = M_NAME;
                end else begin
                    err = 1'b1;
                end
            end else if (mode_reg == M_AFTER) begin
                if (b == CH_DOT) begin
                    m = M_NAME_FIRST;
                end else if (b == CH_OPEN) begin
                    m = M_IDX_PRE;
                end else begin
                    err = 1'b1;
                end
            end else if (mode_reg == M_IDX_PRE) begin
                if (is_digit(b)) begin
                    acc_next = INDEX_WIDTH'(digit_ext);
                    m = M_IDX_NUM;
                end else if (!is_space(b)) begin
                    err = 1'b1;
                end
            end else if (mode_reg == M_IDX_NUM || mode_reg == M_IDX_POST) begin
                if (b == CH_CLOSE) begin
                    user_next.index_valid = 1'b1;
                    data_next.index_value = VALUE_W'(acc_reg);
                    m = M_AFTER;
                end else if (is_space(b)) begin
                    m = M_IDX_POST;
                end else if (is_digit(b) && mode_reg == M_IDX_NUM) begin
                    if (prod[PROD_W-1:INDEX_WIDTH] != '0) begin
                        err = 1'b1;
                    end else begin
                        acc_next = prod[INDEX_WIDTH-1:0];
                    end
                end else begin
                    err = 1'b1;
                end
            end else begin
                err = 1'b1;
            end

            if (err) begin
                data_next             = '0;
                user_next             = '0;
                data_next.parse_error = 1'b1;
                mode_next             = s_tlast ? M_START : M_ERROR;
                if (s_tlast) begin
                    acc_next = '0;
                end
            end else if (s_tlast) begin
                if (m == M_NAME) begin
                    data_next.name_end = 1'b1;
                    data_next.done_ok  = 1'b1;
                end else if (m == M_AFTER) begin
                    data_next.done_ok = 1'b1;
                end else begin
                    data_next             = '0;
                    user_next             = '0;
                    data_next.parse_error = 1'b1;
                end
                mode_next = M_START;
                acc_next  = '0;
            end else begin
                mode_next = m;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_START;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg    <= mode_next;
                acc_reg     <= acc_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import opt_pkg::*;

    typedef enum logic [3:0] {
        PM_START,
        PM_NAME_FIRST,
        PM_NAME,
        PM_ESC,
        PM_IDX_PRE,
        PM_IDX_NUM,
        PM_IDX_POST,
        PM_AFTER,
        PM_ERROR
    } path_mode_t;

    typedef struct packed {
        logic               nc_valid;
        logic [CHAR_W-1:0]  nc;
        logic               name_end;
        logic               idx_valid;
        logic [VALUE_W-1:0] idx;
        logic               done_ok;
        logic               perr;
    } token_t;

    localparam logic [63:0] IDX_LIMIT = (INDEX_WIDTH >= 64) ? {64{1'b1}} :
                                        ((64'd1 << INDEX_WIDTH) - 64'd1);

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;

    path_mode_t          mode = PM_START;
    logic [63:0]         acc = '0;
    token_t              pending_tokens[$];
    logic [CHAR_W-1:0]   path_bytes[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned parsed_items = 0;
    int unsigned mismatches = 0;
    int unsigned n_results = 0;
    int unsigned n_names = 0;
    int unsigned n_indices = 0;
    int unsigned n_ok = 0;
    int unsigned n_errors = 0;

    object_path_tokenizer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic token_t tokenize_byte(input logic [CHAR_W-1:0] ch, input logic last);
        token_t     t;
        path_mode_t m;
        logic       bad;
        logic       digit;
        logic       space;
        logic [63:0] d;
        t = '0;
        m = mode;
        bad = 1'b0;
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        d = 64'(ch) - 64'(CH_ZERO);
        if (m == PM_ERROR) begin
            if (last) begin
                mode = PM_START;
                acc = '0;
            end
            return t;
        end
        if (ch == CH_NUL) begin
            bad = 1'b1;
        end else if (m == PM_START && ch == CH_OPEN) begin
            m = PM_IDX_PRE;
        end else if (m == PM_START || m == PM_NAME_FIRST || m == PM_NAME) begin
            if (ch == CH_DOT || ch == CH_OPEN) begin
                if (m == PM_NAME) begin
                    t.name_end = 1'b1;
                    m = (ch == CH_DOT) ? PM_NAME_FIRST : PM_IDX_PRE;
                end else begin
                    bad = 1'b1;
                end
            end else if (ch == CH_CLOSE) begin
                bad = 1'b1;
            end else if (ch == CH_BSL) begin
                m = PM_ESC;
            end else begin
                t.nc_valid = 1'b1;
                t.nc = ch;
                m = PM_NAME;
            end
        end else if (m == PM_ESC) begin
            if (ch == CH_DOT || ch == CH_OPEN || ch == CH_CLOSE || ch == CH_BSL) begin
                t.nc_valid = 1'b1;
                t.nc = ch;
                m = PM_NAME;
            end else begin
                bad = 1'b1;
            end
        end else if (m == PM_AFTER) begin
            if (ch == CH_DOT)
                m = PM_NAME_FIRST;
            else if (ch == CH_OPEN)
                m = PM_IDX_PRE;
            else
                bad = 1'b1;
        end else if (m == PM_IDX_PRE) begin
            if (digit) begin
                acc = d;
                if (acc > IDX_LIMIT)
                    bad = 1'b1;
                else
                    m = PM_IDX_NUM;
            end else if (!space) begin
                bad = 1'b1;
            end
        end else if (m == PM_IDX_NUM || m == PM_IDX_POST) begin
            if (ch == CH_CLOSE) begin
                t.idx_valid = 1'b1;
                t.idx = acc[VALUE_W-1:0];
                m = PM_AFTER;
            end else if (space) begin
                m = PM_IDX_POST;
            end else if (digit && m == PM_IDX_NUM) begin
                // overflow is caught at the digit that causes it
                if (d > IDX_LIMIT || acc > (IDX_LIMIT - d) / 10)
                    bad = 1'b1;
                else
                    acc = acc * 10 + d;
            end else begin
                bad = 1'b1;
            end
        end else begin
            bad = 1'b1;
        end

        if (bad) begin
            t = '0;
            t.perr = 1'b1;
            mode = last ? PM_START : PM_ERROR;
            if (last)
                acc = '0;
            return t;
        end
        if (last) begin
            if (m == PM_NAME) begin
                t.name_end = 1'b1;
                t.done_ok = 1'b1;
            end else if (m == PM_AFTER) begin
                t.done_ok = 1'b1;
            end else begin
                t = '0;
                t.perr = 1'b1;
            end
            mode = PM_START;
            acc = '0;
            return t;
        end
        mode = m;
        return t;
    endfunction

    // valid is left high on return so back-to-back items need no second assignment
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (mode != PM_ERROR)
            parsed_items++;
        pending_tokens.push_back(tokenize_byte(ch, last));
    endtask

    task automatic send_path(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_path_bytes();
        for (int i = 0; i < path_bytes.size(); i++)
            send_byte(path_bytes[i], i == path_bytes.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_space();
        logic [CHAR_W-1:0] c;
        c = CH_SPACE;
        if ($urandom_range(1) == 1)
            c = CH_TAB + CHAR_W'($urandom_range(4));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_ctrl();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(3))
            0: c = CH_DOT;
            1: c = CH_OPEN;
            2: c = CH_CLOSE;
            default: c = CH_BSL;
        endcase
        return c;
    endfunction

    function automatic void add_name();
        int unsigned       len;
        logic [CHAR_W-1:0] c;
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 20) begin
                path_bytes.push_back(CH_BSL);
                path_bytes.push_back(pick_ctrl());
            end else begin
                do
                    c = CHAR_W'($urandom_range(1, 255));
                while (c == CH_DOT || c == CH_OPEN || c == CH_CLOSE || c == CH_BSL);
                path_bytes.push_back(c);
            end
        end
    endfunction

    function automatic void add_index();
        logic [63:0] v;
        string       digits;
        case ($urandom_range(5))
            0: v = 64'($urandom_range(9));
            1: v = 64'($urandom_range(999));
            2: v = 64'($urandom);
            3: v = 64'hFFFF_FFFF - 64'($urandom_range(3));
            4: v = 64'h1_0000_0000 + 64'($urandom_range(20));
            default: v = {$urandom, $urandom};
        endcase
        digits = $sformatf("%0d", v);
        path_bytes.push_back(CH_OPEN);
        repeat ($urandom_range(2)) path_bytes.push_back(pick_space());
        if ($urandom_range(9) == 0)
            path_bytes.push_back(CH_ZERO);
        for (int i = 0; i < digits.len(); i++)
            path_bytes.push_back(digits[i]);
        repeat ($urandom_range(2)) path_bytes.push_back(pick_space());
        path_bytes.push_back(CH_CLOSE);
    endfunction

    // mostly well-formed paths; some corrupted, truncated or pure noise
    function automatic void make_path();
        int unsigned kind;
        int unsigned segs;
        int unsigned pos;
        path_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 6)) path_bytes.push_back(CHAR_W'($urandom_range(255)));
            return;
        end
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) begin
            if ($urandom_range(1) == 0) begin
                if (s != 0)
                    path_bytes.push_back(CH_DOT);
                add_name();
            end else begin
                add_index();
            end
        end
        if (kind < 12) begin
            pos = $urandom_range(path_bytes.size() - 1);
            path_bytes[pos] = CHAR_W'($urandom_range(255));
        end else if (kind < 16) begin
            while (path_bytes.size() > 1 && $urandom_range(2) != 0)
                void'(path_bytes.pop_back());
        end
    endfunction

    task automatic test_directed_paths();
        send_byte(8'hFF, 1'b1);
        send_path(".");
        send_byte(CH_OPEN, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_CLOSE, 1'b1);
        send_path("\\.\\]\\\\\\[");
        send_path("\\a");
        send_path("]");
        send_path("a..b");
        send_byte(CH_NUL, 1'b1);
        send_path("a[");
        send_path("k[ 42 ].z");
        drain();
    endtask

    task automatic test_random_paths(input int unsigned n);
        int unsigned target;
        target = parsed_items + n;
        while (parsed_items < target) begin
            make_path();
            send_path_bytes();
        end
        drain();
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("result item with nothing expected: tdata %0h tuser %0h",
                       m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                n_results++;
                n_names   += 32'(want.name_end);
                n_indices += 32'(want.idx_valid);
                n_ok      += 32'(want.done_ok);
                n_errors  += 32'(want.perr);
                check_field("name_char_valid", 64'(want.nc_valid), 64'(m_tuser[0]));
                check_field("name_char", 64'(want.nc), 64'(m_tdata[7:0]));
                check_field("name_end", 64'(want.name_end), 64'(m_tdata[8]));
                check_field("index_valid", 64'(want.idx_valid), 64'(m_tuser[1]));
                check_field("index_value", 64'(want.idx), 64'(m_tdata[40:9]));
                check_field("done_ok", 64'(want.done_ok), 64'(m_tdata[41]));
                check_field("parse_error", 64'(want.perr), 64'(m_tdata[42]));
                check_field("tdata padding", '0, 64'(m_tdata[TDATA_W-1:43]));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 13;
        recv_idle_pct = 65;
        test_directed_paths();
        test_random_paths(600);

        send_idle_pct = 65;
        recv_idle_pct = 13;
        test_random_paths(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_paths(550);

        repeat (8) @(posedge aclk);
        $display("Checked %0d result items over %0d parsed path bytes", n_results, parsed_items);
        $display("  %0d names, %0d indices, %0d good paths, %0d errors",
                 n_names, n_indices, n_ok, n_errors);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
